/* rtl/dcsm_pkg.sv */
// Shared codes, widths and register reset values for the charging-dock controller.
package dcsm_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CUR_W    = 16;
   localparam int unsigned THRESH_W = 15;
   localparam int unsigned DEB_W    = 16;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned CSR_IDX_W = 3;

   // request function codes
   localparam logic [1:0] FUNC_TICK      = 2'd0;
   localparam logic [1:0] FUNC_FORCE_OFF = 2'd1;
   localparam logic [1:0] FUNC_CLR_FAULT = 2'd2;
   localparam logic [1:0] FUNC_NOP       = 2'd3;

   // fault codes
   localparam logic [1:0] FAULT_OK       = 2'd0;
   localparam logic [1:0] FAULT_OVERLOAD = 2'd1;
   localparam logic [1:0] FAULT_FORCED   = 2'd2;

   // indicator codes
   localparam logic [2:0] LED_OFF      = 3'd0;
   localparam logic [2:0] LED_DOCKED   = 3'd1;
   localparam logic [2:0] LED_CHARGING = 3'd2;
   localparam logic [2:0] LED_CHARGED  = 3'd3;
   localparam logic [2:0] LED_FAULT    = 3'd4;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OVERCURRENT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGED     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAM_BROKEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAM_CLEAR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DOCK_DEB    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKED     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_AFTER  = 3'd7;

   // control register reset values
   localparam logic [THRESH_W-1:0] RST_OVERCURRENT = 15'd3000;
   localparam logic [THRESH_W-1:0] RST_CHARGED     = 15'd100;
   localparam logic [DEB_W-1:0]    RST_BEAM_BROKEN = 16'd200;
   localparam logic [DEB_W-1:0]    RST_BEAM_CLEAR  = 16'd500;
   localparam logic [DEB_W-1:0]    RST_DOCK_DEB    = 16'd1000;
   localparam logic [DEB_W-1:0]    RST_BLOCKED     = 16'd2500;
   localparam logic [TIME_W-1:0]   RST_STABLE      = 32'd90000;
   localparam logic [TIME_W-1:0]   RST_IDLE_AFTER  = 32'd300000;

   // fixed unblock debounce while charging
   localparam logic [TIME_W-1:0] UNBLOCK_MS = 32'd600;

endpackage

/* rtl/dock_charge_state_machine_core.sv */
// Charging-dock controller: input register, mode update logic and result register.
// Pipeline: a request waits in the input register, then its result is registered; a stalled response holds it.
// Throughput: one request per cycle while the response side keeps up; the only loop is the mode and timer
//   update, which is combinational between the input register and the state registers.
// Reset: synchronous, active high; clears the pipeline valids, mode to boot, fault,
//   gate, idle and settled flags, all debounce timestamps, and loads the register defaults.
module dock_charge_state_machine_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_func,
   input  logic [dcsm_pkg::TIME_W-1:0]        req_now_ms,
   input  logic                               req_beam_present,
   input  logic                               req_obstacles_blocked,
   input  logic signed [dcsm_pkg::CUR_W-1:0]  req_current_ma,
   input  logic                               req_sense_ok,
   input  logic                               req_gate_available,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_mode,
   output logic [1:0]                         rsp_fault_code,
   output logic                               rsp_gate_on,
   output logic                               rsp_idle_flag,
   output logic                               rsp_mode_changed,
   output logic [2:0]                         rsp_led_code,
   // control register write port
   input  logic                               csr_we,
   input  logic [dcsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dcsm_pkg::CSR_W-1:0]         csr_wdata
);
   import dcsm_pkg::*;

   typedef enum logic [2:0] {
      MODE_BOOT        = 3'd0,
      MODE_NOT_DOCKED  = 3'd1,
      MODE_DOCKED_IDLE = 3'd2,
      MODE_CHARGING    = 3'd3,
      MODE_CHARGED     = 3'd4,
      MODE_FAULT       = 3'd5
   } mode_type;

   // ---------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------
   logic [THRESH_W-1:0] oc_ma_ff, chg_ma_ff;
   logic [DEB_W-1:0]    beam_brk_ff, beam_clr_ff, dock_deb_ff, blk_deb_ff;
   logic [TIME_W-1:0]   stable_ff, idle_after_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oc_ma_ff      <= RST_OVERCURRENT;
         chg_ma_ff     <= RST_CHARGED;
         beam_brk_ff   <= RST_BEAM_BROKEN;
         beam_clr_ff   <= RST_BEAM_CLEAR;
         dock_deb_ff   <= RST_DOCK_DEB;
         blk_deb_ff    <= RST_BLOCKED;
         stable_ff     <= RST_STABLE;
         idle_after_ff <= RST_IDLE_AFTER;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OVERCURRENT: oc_ma_ff      <= csr_wdata[THRESH_W-1:0];
            CSR_CHARGED:     chg_ma_ff     <= csr_wdata[THRESH_W-1:0];
            CSR_BEAM_BROKEN: beam_brk_ff   <= csr_wdata[DEB_W-1:0];
            CSR_BEAM_CLEAR:  beam_clr_ff   <= csr_wdata[DEB_W-1:0];
            CSR_DOCK_DEB:    dock_deb_ff   <= csr_wdata[DEB_W-1:0];
            CSR_BLOCKED:     blk_deb_ff    <= csr_wdata[DEB_W-1:0];
            CSR_STABLE:      stable_ff     <= csr_wdata[TIME_W-1:0];
            CSR_IDLE_AFTER:  idle_after_ff <= csr_wdata[TIME_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Input register. It refills in the same cycle it hands its request on, so a
   // transfer can be taken every cycle while the response side keeps up.
   // ---------------------------------------------------------------------------
   logic                in_vld_ff;
   logic [1:0]          in_func_ff;
   logic [TIME_W-1:0]   in_now_ff;
   logic                in_beam_ff, in_blk_ff, in_sense_ff, in_gavail_ff;
   logic [CUR_W-1:0]    in_cur_ff;
   logic                advance;
   logic                rsp_vld_ff;

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff   <= req_func;
         in_now_ff    <= req_now_ms;
         in_beam_ff   <= req_beam_present;
         in_blk_ff    <= req_obstacles_blocked;
         in_cur_ff    <= req_current_ma;
         in_sense_ff  <= req_sense_ok;
         in_gavail_ff <= req_gate_available;
      end
   end

   // ---------------------------------------------------------------------------
   // Controller state
   // ---------------------------------------------------------------------------
   mode_type          mode_ff, mode_in;
   logic [1:0]        fault_ff, fault_in;
   logic              gate_ff, gate_in;
   logic              idle_ff, idle_in;
   logic              settled_ff, settled_in;
   logic [TIME_W-1:0] docked_at_ff, docked_at_in;
   logic [TIME_W-1:0] low_since_ff, low_since_in;
   logic [TIME_W-1:0] charged_at_ff, charged_at_in;
   logic [TIME_W-1:0] blk_since_ff, blk_since_in;
   logic [TIME_W-1:0] unblk_since_ff, unblk_since_in;
   logic [TIME_W-1:0] on_since_ff, on_since_in;
   logic [TIME_W-1:0] off_since_ff, off_since_in;

   // Magnitude of the current; the most negative reading comes out as 32768.
   logic [CUR_W-1:0]  iabs;
   logic              overcurrent, low_current;
   assign iabs        = in_cur_ff[CUR_W-1] ? (~in_cur_ff + 1'b1) : in_cur_ff;
   assign overcurrent = in_sense_ff && gate_ff && (iabs > {1'b0, oc_ma_ff});
   assign low_current = in_sense_ff && (iabs < {1'b0, chg_ma_ff});

   // Elapsed times, all modulo 2^32
   logic [TIME_W-1:0] el_on, el_off, el_dock, el_blk, el_unblk, el_low, el_chg;
   assign el_on    = in_now_ff - on_since_ff;
   assign el_off   = in_now_ff - off_since_ff;
   assign el_dock  = in_now_ff - docked_at_ff;
   assign el_blk   = in_now_ff - blk_since_ff;
   assign el_unblk = in_now_ff - unblk_since_ff;
   assign el_low   = in_now_ff - low_since_ff;
   assign el_chg   = in_now_ff - charged_at_ff;

   logic off_done, on_done;
   assign off_done = el_off >= {{(TIME_W-DEB_W){1'b0}}, beam_clr_ff};
   assign on_done  = el_on  >= {{(TIME_W-DEB_W){1'b0}}, beam_brk_ff};

   always_comb begin
      logic settled_v;
      logic go_idle;
      settled_v      = settled_ff;
      go_idle        = 1'b0;
      mode_in        = mode_ff;
      fault_in       = fault_ff;
      gate_in        = gate_ff;
      idle_in        = idle_ff;
      settled_in     = settled_ff;
      docked_at_in   = docked_at_ff;
      low_since_in   = low_since_ff;
      charged_at_in  = charged_at_ff;
      blk_since_in   = blk_since_ff;
      unblk_since_in = unblk_since_ff;
      on_since_in    = on_since_ff;
      off_since_in   = off_since_ff;

      unique case (in_func_ff)
         FUNC_TICK: begin
            if (overcurrent) begin
               gate_in  = 1'b0;
               fault_in = FAULT_OVERLOAD;
               mode_in  = MODE_FAULT;
            end else begin
               unique case (mode_ff)
                  MODE_BOOT: begin
                     if (in_beam_ff) begin
                        mode_in      = MODE_DOCKED_IDLE;
                        docked_at_in = in_now_ff;
                     end else begin
                        mode_in = MODE_NOT_DOCKED;
                     end
                  end
                  MODE_NOT_DOCKED: begin
                     gate_in      = 1'b0;
                     idle_in      = 1'b0;
                     off_since_in = '0;
                     if (!in_beam_ff) begin
                        on_since_in = '0;
                     end else if (on_since_ff == '0) begin
                        on_since_in = in_now_ff;
                     end else if (on_done) begin
                        docked_at_in = in_now_ff;
                        settled_in   = 1'b0;
                        on_since_in  = '0;
                        mode_in      = MODE_DOCKED_IDLE;
                     end
                  end
                  MODE_DOCKED_IDLE: begin
                     on_since_in = '0;
                     if (!in_beam_ff) begin
                        gate_in = 1'b0;
                        if (off_since_ff == '0) begin
                           off_since_in = in_now_ff;
                        end else if (off_done) begin
                           off_since_in = '0;
                           mode_in      = MODE_NOT_DOCKED;
                        end
                     end else begin
                        off_since_in = '0;
                        settled_v    = settled_ff ||
                                       (el_dock >= {{(TIME_W-DEB_W){1'b0}}, dock_deb_ff});
                        settled_in   = settled_v;
                        if (!in_blk_ff) begin
                           blk_since_in = '0;
                           gate_in      = 1'b0;
                        end else if (settled_v && in_gavail_ff) begin
                           if (blk_since_ff == '0) begin
                              blk_since_in = in_now_ff;
                           end else if (el_blk >= {{(TIME_W-DEB_W){1'b0}}, blk_deb_ff}) begin
                              gate_in      = 1'b1;
                              low_since_in = '0;
                              blk_since_in = '0;
                              mode_in      = MODE_CHARGING;
                           end
                        end
                     end
                  end
                  MODE_CHARGING: begin
                     on_since_in = '0;
                     if (!in_beam_ff) begin
                        gate_in = 1'b0;
                        if (off_since_ff == '0) begin
                           off_since_in = in_now_ff;
                        end else if (off_done) begin
                           off_since_in = '0;
                           mode_in      = MODE_NOT_DOCKED;
                        end
                     end else begin
                        off_since_in = '0;
                        // obstacles cleared: gate drops at once, mode follows after debounce
                        if (in_blk_ff) begin
                           unblk_since_in = '0;
                        end else begin
                           gate_in = 1'b0;
                           if (unblk_since_ff == '0) begin
                              unblk_since_in = in_now_ff;
                           end else if (el_unblk >= UNBLOCK_MS) begin
                              unblk_since_in = '0;
                              blk_since_in   = '0;
                              mode_in        = MODE_DOCKED_IDLE;
                              go_idle        = 1'b1;
                           end
                        end
                        if (!go_idle) begin
                           if (low_current) begin
                              if (low_since_ff == '0) begin
                                 low_since_in = in_now_ff;
                              end else if (el_low >= stable_ff) begin
                                 gate_in       = 1'b0;
                                 charged_at_in = in_now_ff;
                                 idle_in       = 1'b0;
                                 mode_in       = MODE_CHARGED;
                              end
                           end else begin
                              low_since_in = '0;
                           end
                        end
                     end
                  end
                  MODE_CHARGED: begin
                     gate_in     = 1'b0;
                     on_since_in = '0;
                     if ((idle_after_ff != '0) && (el_chg >= idle_after_ff)) begin
                        idle_in = 1'b1;
                     end
                     if (!in_beam_ff) begin
                        if (off_since_ff == '0) begin
                           off_since_in = in_now_ff;
                        end else if (off_done) begin
                           off_since_in = '0;
                           mode_in      = MODE_NOT_DOCKED;
                           idle_in      = 1'b0;
                        end
                     end else begin
                        off_since_in = '0;
                     end
                  end
                  default: begin
                     gate_in = 1'b0;
                  end
               endcase
            end
         end
         FUNC_FORCE_OFF: begin
            gate_in  = 1'b0;
            fault_in = FAULT_FORCED;
            mode_in  = MODE_FAULT;
         end
         FUNC_CLR_FAULT: begin
            if (mode_ff == MODE_FAULT) begin
               gate_in  = 1'b0;
               fault_in = FAULT_OK;
               if (in_beam_ff) begin
                  docked_at_in = in_now_ff;
                  settled_in   = 1'b0;
                  mode_in      = MODE_DOCKED_IDLE;
               end else begin
                  mode_in = MODE_NOT_DOCKED;
               end
            end
         end
         FUNC_NOP: begin
            // unused code: state untouched, response reports it
         end
      endcase
   end

   logic [2:0] led_in;
   always_comb begin
      unique case (mode_in)
         MODE_DOCKED_IDLE: led_in = LED_DOCKED;
         MODE_CHARGING:    led_in = LED_CHARGING;
         MODE_CHARGED:     led_in = LED_CHARGED;
         MODE_FAULT:       led_in = LED_FAULT;
         default:          led_in = LED_OFF;
      endcase
   end

   // ---------------------------------------------------------------------------
   // State and result register: updated together whenever a request advances
   // ---------------------------------------------------------------------------
   logic [2:0] rsp_mode_ff, rsp_led_ff;
   logic [1:0] rsp_fault_ff;
   logic       rsp_gate_ff, rsp_idle_ff, rsp_chg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff     <= 1'b0;
         mode_ff        <= MODE_BOOT;
         fault_ff       <= FAULT_OK;
         gate_ff        <= 1'b0;
         idle_ff        <= 1'b0;
         settled_ff     <= 1'b0;
         docked_at_ff   <= '0;
         low_since_ff   <= '0;
         charged_at_ff  <= '0;
         blk_since_ff   <= '0;
         unblk_since_ff <= '0;
         on_since_ff    <= '0;
         off_since_ff   <= '0;
      end else begin
         if (advance) begin
            rsp_vld_ff     <= 1'b1;
            mode_ff        <= mode_in;
            fault_ff       <= fault_in;
            gate_ff        <= gate_in;
            idle_ff        <= idle_in;
            settled_ff     <= settled_in;
            docked_at_ff   <= docked_at_in;
            low_since_ff   <= low_since_in;
            charged_at_ff  <= charged_at_in;
            blk_since_ff   <= blk_since_in;
            unblk_since_ff <= unblk_since_in;
            on_since_ff    <= on_since_in;
            off_since_ff   <= off_since_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mode_ff  <= mode_in;
         rsp_fault_ff <= (mode_in == MODE_FAULT) ? fault_in : FAULT_OK;
         rsp_gate_ff  <= gate_in;
         rsp_idle_ff  <= idle_in;
         rsp_chg_ff   <= (mode_in != mode_ff);
         rsp_led_ff   <= led_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_fault_code   = rsp_fault_ff;
   assign rsp_gate_on      = rsp_gate_ff;
   assign rsp_idle_flag    = rsp_idle_ff;
   assign rsp_mode_changed = rsp_chg_ff;
   assign rsp_led_code     = rsp_led_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   // gate may only be driven while charging
   a_gate_only_charging: assert property (@(posedge clock) disable iff (reset)
      gate_ff |-> (mode_ff == MODE_CHARGING))
      else $error("gate on outside charging");

   // fault code reported only in fault mode
   a_fault_code_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_fault_code == FAULT_OK) || (rsp_mode == MODE_FAULT)))
      else $error("fault code outside fault mode");

   // boot is never re-entered once left
   a_no_boot_return: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode_changed) |-> (rsp_mode != MODE_BOOT))
      else $error("mode changed back to boot");

   // a transfer into a full, stalled input register would drop a request
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |-> !req_ready)
      else $error("request accepted over a stalled one");

endmodule
